>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A stalled transfer keeps valid high and its data unchanged.
`define CHK_HOLD(lbl, clk, rstn, vld, rdy, data, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) \
        (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

>>> hw/rtl/tass_pkg.sv
// Types, constants and the half-step coil table of the two-axis stepper sequencer.
// No dependencies; imported by the configuration, step logic and top-level modules.
package tass_pkg;

    localparam int POS_BITS      = 32;
    localparam int SHAKE_REPEATS = 5;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CODE_BITS     = 4;
    localparam int IN_BYTES_BITS = 8;
    localparam int OUT_BITS      = 80;

    typedef enum logic [3:0] {
        OP_IDLE    = 4'd0,
        OP_BREW    = 4'd1,
        OP_LDOWN   = 4'd2,
        OP_LUP     = 4'd3,
        OP_SHAKE   = 4'd4,
        OP_DISCARD = 4'd5,
        OP_HOME    = 4'd6,
        OP_RIGHT   = 4'd7,
        OP_LEFT    = 4'd8,
        OP_JUP     = 4'd9,
        OP_JDOWN   = 4'd10,
        OP_CAL     = 4'd11
    } op_t;

    // Brew / shake sequence phases
    typedef enum logic [2:0] {
        PH_HOME    = 3'd0,
        PH_DOWN    = 3'd1,
        PH_CHECK   = 3'd2,
        PH_RISE    = 3'd3,
        PH_FALL    = 3'd4,
        PH_UP      = 3'd5,
        PH_DISCARD = 3'd6
    } phase_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_HOME    = 3'd0,
        REG_DISCARD = 3'd1,
        REG_UP      = 3'd2,
        REG_DOWN    = 3'd3,
        REG_SHAKE   = 3'd4,
        REG_JOG     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] home;
        logic [31:0] discard;
        logic [31:0] up;
        logic [31:0] down;
        logic [15:0] shake_height;
        logic [15:0] jog_steps;
    } cfg_t;

    typedef struct packed {
        logic [POS_BITS-1:0] lift_pos;
        logic [POS_BITS-1:0] carr_pos;
        logic [3:0]          lift_coil;
        logic [3:0]          carr_coil;
        logic                first_pending;
        op_t                 op;
        phase_t              phase;
        logic [2:0]          shake_cnt;
        logic [15:0]         jog_cnt;
    } state_t;

    typedef struct packed {
        logic [31:0] carriage_position;
        logic [31:0] lift_position;
        logic        done;
        logic        accepted;
        logic        busy;
        logic [3:0]  carriage_coils;
        logic [3:0]  lift_coils;
    } result_t;

    function automatic logic [3:0] coil_pattern(input logic [2:0] idx);
        logic [3:0] pat;
        unique case (idx)
            3'd0: pat = 4'b0001;
            3'd1: pat = 4'b0011;
            3'd2: pat = 4'b0010;
            3'd3: pat = 4'b0110;
            3'd4: pat = 4'b0100;
            3'd5: pat = 4'b1100;
            3'd6: pat = 4'b1000;
            3'd7: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

>>> hw/rtl/tass_cfg_regs.sv
// Configuration register file: targets, shake height and jog length.
// Depends on tass_pkg.
module tass_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tass_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [31:0]                         cfg_data,
    output tass_pkg::cfg_t                      cfg
);
    import tass_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOME:    cfg_next.home         = cfg_data;
                REG_DISCARD: cfg_next.discard      = cfg_data;
                REG_UP:      cfg_next.up           = cfg_data;
                REG_DOWN:    cfg_next.down         = cfg_data;
                REG_SHAKE:   cfg_next.shake_height = cfg_data[15:0];
                REG_JOG:     cfg_next.jog_steps    = cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.home         <= 32'sd0;
            cfg_reg.discard      <= -32'sd5100;
            cfg_reg.up           <= 32'sd0;
            cfg_reg.down         <= -32'sd3500;
            cfg_reg.shake_height <= 16'd1500;
            cfg_reg.jog_steps    <= 16'd1000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hw/rtl/tass_step_logic.sv
// One-pass item logic: command decode or step, then the phase settle, then the result.
// Depends on tass_pkg.
module tass_step_logic (
    input  tass_pkg::cfg_t                  cfg,
    input  tass_pkg::state_t                st,
    input  logic                            action,
    input  logic [tass_pkg::CODE_BITS-1:0]  code,
    output tass_pkg::state_t                st_next,
    output tass_pkg::result_t               res
);
    import tass_pkg::*;

    state_t                     stepped;
    logic                       run_settle;
    logic                       accepted;

    logic [POS_BITS-1:0]        lift_inc;
    logic [POS_BITS-1:0]        lift_dec;
    logic [POS_BITS-1:0]        carr_inc;
    logic [POS_BITS-1:0]        carr_dec;

    logic signed [POS_BITS-1:0] lp_s;
    logic signed [POS_BITS-1:0] cp_s;
    logic signed [POS_BITS-1:0] lp_next_s;
    logic signed [POS_BITS-1:0] cp_next_s;
    logic signed [31:0]         home_s;
    logic signed [31:0]         discard_s;
    logic signed [31:0]         up_s;
    logic signed [31:0]         down_s;
    logic signed [33:0]         shake_top;

    logic                       c_home_ok;
    logic                       l_down_ok;
    logic                       at_home;
    logic                       top_ok;
    logic                       up_ok;
    logic                       disc_ok;

    assign accepted = !action && !st.first_pending && (st.op == OP_IDLE) && (code <= OP_CAL);

    assign lift_inc = st.lift_pos + POS_BITS'(1);
    assign lift_dec = st.lift_pos - POS_BITS'(1);
    assign carr_inc = st.carr_pos + POS_BITS'(1);
    assign carr_dec = st.carr_pos - POS_BITS'(1);

    // Command decode or one step
    always_comb
    begin
        stepped    = st;
        run_settle = 1'b0;
        if (action)
        begin
            if (st.op != OP_IDLE)
            begin
                run_settle = 1'b1;
                unique case (st.op)
                    OP_LDOWN:
                    begin
                        stepped.lift_pos  = lift_dec;
                        stepped.lift_coil = coil_pattern(lift_dec[2:0]);
                    end
                    OP_LUP:
                    begin
                        stepped.lift_pos  = lift_inc;
                        stepped.lift_coil = coil_pattern(lift_inc[2:0]);
                    end
                    OP_DISCARD:
                    begin
                        stepped.carr_pos  = carr_dec;
                        stepped.carr_coil = coil_pattern(carr_dec[2:0]);
                    end
                    OP_HOME:
                    begin
                        stepped.carr_pos  = carr_inc;
                        stepped.carr_coil = coil_pattern(carr_inc[2:0]);
                    end
                    OP_RIGHT:
                    begin
                        stepped.carr_pos  = carr_inc;
                        stepped.carr_coil = coil_pattern(carr_inc[2:0]);
                        stepped.jog_cnt   = st.jog_cnt - 16'd1;
                    end
                    OP_LEFT:
                    begin
                        stepped.carr_pos  = carr_dec;
                        stepped.carr_coil = coil_pattern(carr_dec[2:0]);
                        stepped.jog_cnt   = st.jog_cnt - 16'd1;
                    end
                    OP_JUP:
                    begin
                        stepped.lift_pos  = lift_inc;
                        stepped.lift_coil = coil_pattern(lift_inc[2:0]);
                        stepped.jog_cnt   = st.jog_cnt - 16'd1;
                    end
                    OP_JDOWN:
                    begin
                        stepped.lift_pos  = lift_dec;
                        stepped.lift_coil = coil_pattern(lift_dec[2:0]);
                        stepped.jog_cnt   = st.jog_cnt - 16'd1;
                    end
                    OP_BREW, OP_SHAKE:
                    begin
                        unique case (st.phase)
                            PH_HOME:
                            begin
                                stepped.carr_pos  = carr_inc;
                                stepped.carr_coil = coil_pattern(carr_inc[2:0]);
                            end
                            PH_DOWN, PH_FALL:
                            begin
                                stepped.lift_pos  = lift_dec;
                                stepped.lift_coil = coil_pattern(lift_dec[2:0]);
                            end
                            PH_RISE, PH_UP:
                            begin
                                stepped.lift_pos  = lift_inc;
                                stepped.lift_coil = coil_pattern(lift_inc[2:0]);
                            end
                            PH_DISCARD:
                            begin
                                stepped.carr_pos  = carr_dec;
                                stepped.carr_coil = coil_pattern(carr_dec[2:0]);
                            end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
        end
        else if (st.first_pending)
        begin
            stepped.first_pending = 1'b0;
        end
        else if (accepted)
        begin
            if (code == OP_CAL)
            begin
                stepped.lift_pos = '0;
                stepped.carr_pos = '0;
            end
            else if (code != OP_IDLE)
            begin
                stepped.op        = op_t'(code);
                stepped.phase     = (code == OP_SHAKE) ? PH_CHECK : PH_HOME;
                stepped.shake_cnt = 3'd0;
                stepped.jog_cnt   = (code >= OP_RIGHT) ? cfg.jog_steps : 16'd0;
                run_settle        = 1'b1;
            end
        end
    end

    // Limit compares on the positions after the step
    assign lp_s      = stepped.lift_pos;
    assign cp_s      = stepped.carr_pos;
    assign home_s    = cfg.home;
    assign discard_s = cfg.discard;
    assign up_s      = cfg.up;
    assign down_s    = cfg.down;
    assign shake_top = {{2{cfg.down[31]}}, cfg.down} + {18'd0, cfg.shake_height};

    assign c_home_ok = cp_s >= home_s;
    assign l_down_ok = lp_s <= down_s;
    assign at_home   = (cp_s == home_s) && (lp_s == down_s);
    assign top_ok    = lp_s >= shake_top;
    assign up_ok     = lp_s >= up_s;
    assign disc_ok   = cp_s <= discard_s;

    // Settle: walk the phases that need no step. Positions stay fixed here, so
    // repeated shakes that need no step collapse to the end count.
    always_comb
    begin
        logic live;
        logic is_shake;
        st_next  = stepped;
        live     = 1'b1;
        is_shake = (stepped.op == OP_SHAKE);
        if (run_settle)
        begin
            unique case (stepped.op)
                OP_LDOWN:   if (l_down_ok) st_next.op = OP_IDLE;
                OP_LUP:     if (up_ok)     st_next.op = OP_IDLE;
                OP_DISCARD: if (disc_ok)   st_next.op = OP_IDLE;
                OP_HOME:    if (c_home_ok) st_next.op = OP_IDLE;
                OP_RIGHT, OP_LEFT, OP_JUP, OP_JDOWN:
                begin
                    if (stepped.jog_cnt == 16'd0)
                        st_next.op = OP_IDLE;
                end
                OP_BREW, OP_SHAKE:
                begin
                    if (st_next.phase == PH_HOME)
                    begin
                        if (c_home_ok) st_next.phase = PH_DOWN;
                        else           live = 1'b0;
                    end
                    if (live && st_next.phase == PH_DOWN)
                    begin
                        if (l_down_ok) st_next.phase = PH_CHECK;
                        else           live = 1'b0;
                    end
                    if (live && st_next.phase == PH_RISE)
                    begin
                        if (top_ok) st_next.phase = PH_FALL;
                        else        live = 1'b0;
                    end
                    if (live && st_next.phase == PH_FALL)
                    begin
                        if (!l_down_ok)
                            live = 1'b0;
                        else if (is_shake)
                        begin
                            st_next.op = OP_IDLE;
                            live       = 1'b0;
                        end
                        else
                        begin
                            st_next.shake_cnt = st_next.shake_cnt + 3'd1;
                            st_next.phase     = PH_CHECK;
                        end
                    end
                    if (live && st_next.phase == PH_CHECK)
                    begin
                        if (is_shake)
                        begin
                            if (at_home && !top_ok)
                                st_next.phase = PH_RISE;
                            else
                                st_next.op = OP_IDLE;
                            live = 1'b0;
                        end
                        else if (st_next.shake_cnt >= 3'(SHAKE_REPEATS))
                            st_next.phase = PH_UP;
                        else if (at_home && !top_ok)
                        begin
                            st_next.phase = PH_RISE;
                            live          = 1'b0;
                        end
                        else
                        begin
                            // skipped or stepless shakes run the count out
                            st_next.shake_cnt = 3'(SHAKE_REPEATS);
                            st_next.phase     = PH_UP;
                        end
                    end
                    if (live && st_next.phase == PH_UP)
                    begin
                        if (up_ok) st_next.phase = PH_DISCARD;
                        else       live = 1'b0;
                    end
                    if (live && st_next.phase == PH_DISCARD)
                    begin
                        if (disc_ok) st_next.op = OP_IDLE;
                    end
                end
                default: st_next.op = OP_IDLE;
            endcase
        end
    end

    assign lp_next_s = st_next.lift_pos;
    assign cp_next_s = st_next.carr_pos;

    // Result fields
    always_comb
    begin
        res.lift_coils        = st_next.lift_coil;
        res.carriage_coils    = st_next.carr_coil;
        res.busy              = (st_next.op != OP_IDLE);
        res.accepted          = accepted;
        res.done              = (action ? (st.op != OP_IDLE) : accepted)
                                && (st_next.op == OP_IDLE);
        res.lift_position     = 32'(lp_next_s);
        res.carriage_position = 32'(cp_next_s);
    end

endmodule

>>> hw/rtl/two_axis_stepper_sequencer_core.sv
// Top level of the two-axis stepper sequencer: input register, state, result register.
// Depends on tass_pkg, tass_cfg_regs and tass_step_logic.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    s_tuser = action, s_tdata = command_code
// m_*       out  m_tvalid/m_tready    m_tdata = coils, flags, positions
// cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per clock sustained while m_tready is high; each item passes the input
// register, then a single pass of step and settle logic into the result register,
// which also updates the axis state.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds in the output register while one more item waits in the
// input register; s_tready drops only when both are full.
module two_axis_stepper_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tass_pkg::IN_BYTES_BITS-1:0]  s_tdata,   // [3:0] command_code
    input  logic                                s_tuser,   // [0] action
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] lift_coils, [7:4] carriage_coils, [8] busy_res, [9] accepted,
    // [10] done_res, [42:11] lift_position, [74:43] carriage_position, rest zero
    output logic [tass_pkg::OUT_BITS-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tass_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [31:0]                         cfg_data
);
    import tass_pkg::*;

    cfg_t                   cfg;
    state_t                 state_reg;
    state_t                 state_next;
    result_t                res_next;
    result_t                res_reg;

    logic                   in_valid_reg;
    logic                   in_action_reg;
    logic [CODE_BITS-1:0]   in_code_reg;
    logic                   out_valid_reg;
    logic                   advance;

    tass_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tass_step_logic u_step (
        .cfg     (cfg),
        .st      (state_reg),
        .action  (in_action_reg),
        .code    (in_code_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_BITS - $bits(result_t)){1'b0}}, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.lift_pos      <= '0;
            state_reg.carr_pos      <= '0;
            state_reg.lift_coil     <= 4'd0;
            state_reg.carr_coil     <= 4'd0;
            state_reg.first_pending <= 1'b1;
            state_reg.op            <= OP_IDLE;
            state_reg.phase         <= PH_HOME;
            state_reg.shake_cnt     <= 3'd0;
            state_reg.jog_cnt       <= 16'd0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= s_tuser;
            in_code_reg   <= s_tdata[CODE_BITS-1:0];
        end
        if (advance)
            res_reg <= res_next;
    end

endmodule

>>> hw/rtl/tass_checker.sv
// Port-level checker for the two-axis stepper sequencer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tass_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    logic       busy_bit;
    logic       acc_bit;
    logic       done_bit;
    logic [3:0] lift_c;
    logic [3:0] carr_c;

    assign lift_c   = m_tdata[3:0];
    assign carr_c   = m_tdata[7:4];
    assign busy_bit = m_tdata[8];
    assign acc_bit  = m_tdata[9];
    assign done_bit = m_tdata[10];

    `CHK_HOLD(a_out_hold, clk, rst_n, m_tvalid, m_tready, m_tdata, "result changed while stalled")

    // an accepted command either finishes at once or leaves a move running
    `CHK_ASSERT(a_accept_outcome, clk, rst_n, (m_tvalid && acc_bit) |-> (busy_bit || done_bit), "accepted neither busy nor done")

    `CHK_ASSERT(a_done_not_busy, clk, rst_n, m_tvalid |-> !(busy_bit && done_bit), "done and busy together")

    // half-step patterns energize at most two coils
    `CHK_ASSERT(a_coil_count, clk, rst_n, m_tvalid |-> ($countones({lift_c, 4'd0}) <= 2), "lift coil count")

    `CHK_ASSERT(a_carr_coil_count, clk, rst_n, m_tvalid |-> ($countones(carr_c) <= 2), "carriage coil count")

endmodule

bind two_axis_stepper_sequencer_core tass_checker u_tass_checker (.*);
